[rtl/lifo_stack_with_search_assert.svh]
// Assertion macros used by the stack datapath.
`ifndef LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lifo stack assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lifo stack assertion failed");

`endif

[rtl/lsws_pkg.sv]
// Shared constants, codes and control types for the LIFO stack with search.
package lsws_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int VALUE_W             = 32;
    localparam int CMD_W               = 2;
    localparam int OCC_W               = 7;
    localparam int STATUS_W            = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic pop_cap;
        logic scan;
        logic load_out;
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic scan_done;
    } sts_t;

endpackage

[rtl/lsws_if.sv]
// Request and response channel interfaces for the LIFO stack.
interface lsws_req_if
    import lsws_pkg::*;
();
    logic                      valid;
    logic                      ready;
    cmd_t                      command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface lsws_rsp_if
    import lsws_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] top_value;
    logic                      found;
    logic [OCC_W-1:0]          occupancy;
    status_t                   status;

    modport source (output valid, output top_value, output found, output occupancy,
                    output status, input ready);
    modport sink   (input valid, input top_value, input found, input occupancy,
                    input status, output ready);
endinterface

[rtl/lifo_stack_with_search.sv]
// LIFO stack of signed 32-bit words with a membership search.
// Channels: req carries command (push, pop, read top, find) and value; rsp
// returns one item per request with top_value, found, occupancy and status.
// Both channels move an item when valid and ready are high at a clock edge.
// Items are handled one at a time; req.ready is high only while idle.
// A find scans up to STACK_DEPTH entries, none on an empty stack; the scan
// reads one entry per cycle through the single read port of the entry RAM
// and stops at the first match.
// Pop and read top on an empty stack report underflow and change nothing;
// push on a full stack is dropped and reports overflow.
// The response sits in an output register: the next request is accepted
// while it waits, and that request's response holds until rsp.ready.
// Reset (rst_n low, asynchronous) empties the stack and clears valid; the
// entry RAM is not cleared and needs no clearing pass.
module lifo_stack_with_search
    import lsws_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    lsws_req_if.sink          req,
    lsws_rsp_if.source        rsp
);
    ctl_t ctl;
    sts_t sts;

    lsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    lsws_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_command (req.command),
        .in_value   (req.value),
        .top_value  (rsp.top_value),
        .found      (rsp.found),
        .occupancy  (rsp.occupancy),
        .status     (rsp.status)
    );
endmodule

[rtl/lsws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/lsws_ctrl.sv]
// Controller state machine: sequences each item and owns the handshakes.
module lsws_ctrl
    import lsws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output ctl_t ctl,
    input  sts_t sts
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_POPCAP = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.cmd == CMD_POP)
                begin
                    state_next = S_POPCAP;
                end
                else if (sts.cmd == CMD_FIND)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POPCAP:
            begin
                ctl.pop_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[rtl/lsws_dpath.sv]
// Datapath: entry store, count, cached top, search scan and result register.
`include "lifo_stack_with_search_assert.svh"
module lsws_dpath
    import lsws_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_t                      ctl,
    output sts_t                      sts,
    input  cmd_t                      in_command,
    input  logic signed [VALUE_W-1:0] in_value,
    output logic signed [VALUE_W-1:0] top_value,
    output logic                      found,
    output logic [OCC_W-1:0]          occupancy,
    output status_t                   status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    cmd_t                 cmd_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [VALUE_W-1:0]   top_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        left_reg;
    logic [AW-1:0]        idx_reg;
    logic                 pend_reg;
    logic                 found_reg;
    status_t              status_reg;

    logic signed [VALUE_W-1:0] top_out_reg;
    logic                      found_out_reg;
    logic [OCC_W-1:0]          occ_out_reg;
    status_t                   status_out_reg;

    logic                 full;
    logic                 empty;
    logic [CW-1:0]        count_m1;
    logic [CW-1:0]        count_m2;
    logic                 ram_we;
    logic                 pop_ok;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 issue;
    logic [CW+OCC_W-1:0]  occ_ext;

    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign issue    = ctl.scan && (left_reg != '0) && !found_reg;
    assign ram_we   = ctl.exec && (cmd_reg == CMD_PUSH) && !full;
    assign pop_ok   = ctl.exec && (cmd_reg == CMD_POP) && !empty;
    // during a scan walk down from the top; on pop fetch the new top
    assign ram_raddr = ctl.scan ? idx_reg : count_m2[AW-1:0];

    assign sts.cmd       = cmd_reg;
    assign sts.scan_done = found_reg || ((left_reg == '0) && !pend_reg);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.exec)
        begin
            if (cmd_reg == CMD_PUSH && !full)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (cmd_reg == CMD_POP && !empty)
            begin
                count_next = count_m1;
            end
        end
    end

    lsws_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.load_item)
            begin
                found_reg <= 1'b0;
            end
            else if (pend_reg && ctl.scan && (ram_rdata == value_reg))
            begin
                found_reg <= 1'b1;
            end
            if (ctl.exec && cmd_reg == CMD_FIND)
            begin
                left_reg <= count_reg;
            end
            else if (issue)
            begin
                left_reg <= left_reg - CW'(1);
            end
            else if (ctl.scan && found_reg)
            begin
                left_reg <= '0;
            end
            pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg   <= in_command;
            value_reg <= in_value;
        end
        if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        status_reg <= ST_OVERFLOW;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        top_reg    <= value_reg;
                    end
                end
                CMD_POP, CMD_TOP:
                begin
                    status_reg <= empty ? ST_UNDERFLOW : ST_OK;
                end
                CMD_FIND:
                begin
                    status_reg <= ST_OK;
                    idx_reg    <= count_m1[AW-1:0];
                end
                default:
                begin
                    status_reg <= ST_OK;
                end
            endcase
        end
        if (ctl.pop_cap)
        begin
            top_reg <= ram_rdata;
        end
        if (issue)
        begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (ctl.load_out)
        begin
            top_out_reg    <= empty ? '0 : top_reg;
            found_out_reg  <= found_reg;
            occ_out_reg    <= occ_ext[OCC_W-1:0];
            status_out_reg <= status_reg;
        end
    end

    assign occ_ext   = {{OCC_W{1'b0}}, count_reg};
    assign top_value = top_out_reg;
    assign found     = found_out_reg;
    assign occupancy = occ_out_reg;
    assign status    = status_out_reg;

    `LSWS_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `LSWS_ASSERT_NEXT(a_push_grows, clk, rst_n, ram_we, count_reg == $past(count_reg) + CW'(1))
    `LSWS_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, pop_ok, count_reg == $past(count_reg) - CW'(1))
    `LSWS_ASSERT_IMP(a_found_on_find, clk, rst_n, found_reg, cmd_reg == CMD_FIND)
endmodule

[dv/stack_checker.sv]
// Checker for the LIFO stack: watches both channels, predicts each response and compares.
module stack_checker
    import lsws_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    lsws_req_if  req,
    lsws_rsp_if  rsp,
    output int   err_count,
    output int   pending,
    output int   n_results,
    output int   n_overflow,
    output int   n_underflow,
    output int   n_hits
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic                      found;
        logic [OCC_W-1:0]          occupancy;
        status_t                   status;
    } stack_result_t;

    logic signed [VALUE_W-1:0] words [STACK_DEPTH];
    int unsigned               held;
    stack_result_t             expected_results[$];

    // Update the shadow stack and return the response this command should give.
    function automatic stack_result_t apply_command(cmd_t cmd, logic signed [VALUE_W-1:0] word);
        stack_result_t r;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH:
            begin
                if (held >= STACK_DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    words[held] = word;
                    held++;
                end
            end
            CMD_POP:
            begin
                if (held == 0)
                    r.status = ST_UNDERFLOW;
                else
                    held--;
            end
            CMD_TOP:
            begin
                if (held == 0)
                    r.status = ST_UNDERFLOW;
            end
            default:
            begin
                for (int i = 0; i < held; i++)
                    if (words[i] == word)
                        r.found = 1'b1;
            end
        endcase
        r.top_value = (held == 0) ? '0 : words[held - 1];
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            // Retire the response first: it always belongs to an earlier request.
            if (rsp.valid && rsp.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $error("response with no request outstanding: top_value %0d", rsp.top_value);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d", want.top_value, rsp.top_value);
                        err_count++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        err_count++;
                    end
                    if (rsp.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
                        err_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        err_count++;
                    end
                    if (want.status == ST_OVERFLOW)
                        n_overflow++;
                    if (want.status == ST_UNDERFLOW)
                        n_underflow++;
                    if (want.found)
                        n_hits++;
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_command(req.command, req.value));
            pending = expected_results.size();
        end
    end

endmodule

[dv/testbench.sv]
// Top of the LIFO stack test: clock, reset, request and response traffic, verdict.
module testbench;
    import lsws_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 830;
    localparam int PHASE_LEN      = 120;
    localparam int LONG_HOLD      = 200;
    localparam int HOLD_AT_RESULT = 300;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WORD_HISTORY   = 64;

    logic clk = 1'b0;
    logic rst_n;
    logic tx_idle_on;
    logic rx_idle_on;
    int   n_sent;
    int   err_count;
    int   pending;
    int   n_results;
    int   n_overflow;
    int   n_underflow;
    int   n_hits;

    logic signed [VALUE_W-1:0] pushed_words[$];

    lsws_req_if req_ch();
    lsws_rsp_if rsp_ch();

    lifo_stack_with_search u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    stack_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .err_count   (err_count),
        .pending     (pending),
        .n_results   (n_results),
        .n_overflow  (n_overflow),
        .n_underflow (n_underflow),
        .n_hits      (n_hits)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Offer one item, after a random gap while tx_idle_on is set, and hold it until accepted.
    task automatic send_item(input cmd_t cmd, input logic signed [VALUE_W-1:0] word);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= word;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        n_sent++;
        if (cmd == CMD_PUSH)
        begin
            pushed_words.push_back(word);
            if (pushed_words.size() > WORD_HISTORY)
                void'(pushed_words.pop_front());
        end
    endtask

    // Stop offering and hold until every response is back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        // let the checker log the last accepted item first
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return VALUE_W'($signed($urandom_range(0, 7)) - 4);
            default: return $urandom();
        endcase
    endfunction

    // Mode 0 fills the stack, 1 churns around the middle, 2 drains it.
    function automatic cmd_t pick_command(int mode);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        push_lim = (mode == 0) ? 80 : (mode == 1) ? 40 : 15;
        pop_lim  = (mode == 0) ? 88 : (mode == 1) ? 70 : 75;
        if (r < push_lim)
            return CMD_PUSH;
        if (r < pop_lim)
            return CMD_POP;
        if (r < pop_lim + 10)
            return CMD_TOP;
        return CMD_FIND;
    endfunction

    // Response side: random stalls, plus one long hold-off to back up the block.
    initial
    begin
        int stall;
        int rx_count;
        rx_count = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (rx_count == HOLD_AT_RESULT)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_ch.valid);
            rx_count++;
        end
    end

    initial
    begin
        int mode;
        int phase;
        cmd_t cmd;
        logic signed [VALUE_W-1:0] word;
        logic signed [VALUE_W-1:0] w_min;
        logic signed [VALUE_W-1:0] w_max;

        w_min = {1'b1, {(VALUE_W-1){1'b0}}};
        w_max = {1'b0, {(VALUE_W-1){1'b1}}};
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_PUSH;
        req_ch.value   = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        n_sent         = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-stack cases
        send_item(CMD_TOP, '0);
        send_item(CMD_POP, '0);
        send_item(CMD_FIND, '0);
        // Extremes, with a duplicate of the minimum on top
        send_item(CMD_PUSH, w_min);
        send_item(CMD_PUSH, w_max);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, -1);
        send_item(CMD_PUSH, 1);
        send_item(CMD_PUSH, w_min);
        send_item(CMD_TOP, '0);
        send_item(CMD_FIND, w_max);
        send_item(CMD_FIND, 32'h5A5A_5A5A);
        send_item(CMD_POP, '0);
        send_item(CMD_FIND, w_min);
        send_item(CMD_POP, '0);
        send_item(CMD_FIND, 1);
        repeat (4) send_item(CMD_POP, '0);
        send_item(CMD_POP, '0);
        send_item(CMD_TOP, '0);
        wait_for_results();

        mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                if (i > 0)
                    wait_for_results();
                phase = i / PHASE_LEN;
                mode = phase % 3;
                tx_idle_on = (phase % 4) != 3;
                rx_idle_on = (phase % 4) != 3 && (phase % 4) != 1;
            end
            cmd = pick_command(mode);
            if (cmd == CMD_FIND && pushed_words.size() > 0 && $urandom_range(0, 9) < 6)
                word = pushed_words[$urandom_range(0, pushed_words.size() - 1)];
            else
                word = pick_word();
            send_item(cmd, word);
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses across fill, churn and drain phases",
                 n_sent, n_results);
        $display("Saw %0d overflows, %0d underflows, %0d find hits, one long output stall",
                 n_overflow, n_underflow, n_hits);
        if (err_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/lsws_pkg.sv
rtl/lsws_if.sv
rtl/lsws_ram.sv
rtl/lsws_ctrl.sv
rtl/lsws_dpath.sv
rtl/lifo_stack_with_search.sv
dv/stack_checker.sv
dv/testbench.sv
